// ===== src/dsl_pkg.sv =====
// Shared types and constants of the DFA spec lexer.
`default_nettype none

package dsl_pkg;

	localparam int CNT_W = 16;
	localparam int SYM_W = 9;

	typedef enum logic [3:0] {
		TK_SIGMA  = 4'd0,
		TK_START  = 4'd1,
		TK_FINAL  = 4'd2,
		TK_CHAR   = 4'd3,
		TK_N      = 4'd4,
		TK_LBRACE = 4'd5,
		TK_RBRACE = 4'd6,
		TK_EQUALS = 4'd7,
		TK_COMMA  = 4'd8,
		TK_NUMBER = 4'd9,
		TK_EOF    = 4'd10,
		TK_UNDEF  = 4'd11
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [31:0] value;
		logic [15:0] line;
		logic [15:0] col;
	} tok_t;

	typedef struct packed {
		logic step;
		logic sel_input;
		logic flush;
		logic clear;
	} dsl_cmd_t;

	typedef struct packed {
		logic emit;
		logic rescan;
		logic q_last;
		logic skip;
		logic in_end;
		logic pend_valid;
		logic out_free;
	} dsl_sts_t;

endpackage

`default_nettype wire

// ===== src/dsl_ctrl.sv =====
// Controller of the DFA spec lexer: sequences input beats, rescans and token hand-off.
`default_nettype none

module dsl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              byte_valid,
	output logic                   byte_stall,
	input  wire dsl_pkg::dsl_sts_t sts,
	output dsl_pkg::dsl_cmd_t      cmd
);
	import dsl_pkg::*;

	typedef enum logic {S_IDLE, S_RUN} state_t;

	state_t state_q, state_n;
	logic   fin_q, fin_n;

	always_comb begin
		cmd        = '0;
		byte_stall = 1'b1;
		state_n    = state_q;
		fin_n      = fin_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.sel_input = 1'b1;
				byte_stall    = sts.pend_valid;
				cmd.flush     = sts.pend_valid && sts.out_free;
				if (byte_valid && !sts.pend_valid && !sts.skip) begin
					cmd.step = 1'b1;
					if (sts.rescan) begin
						state_n = S_RUN;
						fin_n   = sts.in_end;
					end else begin
						cmd.clear = sts.in_end;
					end
				end
			end
			S_RUN: begin
				if (!(sts.emit && sts.pend_valid && !sts.out_free)) begin
					cmd.step = 1'b1;
					if (!sts.rescan && sts.q_last) begin
						state_n   = S_IDLE;
						cmd.clear = fin_q;
					end
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_n;
			fin_q   <= fin_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/dsl_dpath.sv =====
// Datapath of the DFA spec lexer: scan state, held bytes, rescan queue and token registers.
`default_nettype none

module dsl_dpath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        char_byte,
	input  wire logic              end_of_input,
	input  wire dsl_pkg::dsl_cmd_t cmd,
	output dsl_pkg::dsl_sts_t      sts,
	output logic [3:0]             token_kind,
	output logic signed [31:0]     token_value,
	output logic [15:0]            line_number,
	output logic [15:0]            end_column,
	output logic                   last_of_run,
	output logic                   token_valid,
	input  wire logic              token_stall
);
	import dsl_pkg::*;

	typedef enum logic [2:0] {
		M_IDLE, M_HOLD, M_SIGN, M_UNUM, M_SNUM, M_DISCARD, M_LINE_END
	} scan_mode_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
			input logic [2:0] a);
		logic [CNT_W:0] s;
		s = {1'b0, v} + {{(CNT_W-2){1'b0}}, a};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	function automatic logic [15:0] rep16(input logic [CNT_W-1:0] v);
		logic [32:0] t;
		t = 33'(v);
		return (t > 33'h0FFFF) ? 16'hFFFF : t[15:0];
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
		logic [39:0] w;
		unique case (k)
			2'd0:    w = "sigma";
			2'd1:    w = "start";
			default: w = "final";
		endcase
		return w[8*(4-int'(i)) +: 8];
	endfunction

	function automatic tok_kind_t single_kind(input logic [7:0] c);
		tok_kind_t k;
		priority if (c >= "a" && c <= "j") k = TK_CHAR;
		else if (c == "n") k = TK_N;
		else if (c == "{") k = TK_LBRACE;
		else if (c == "}") k = TK_RBRACE;
		else if (c == "=") k = TK_EQUALS;
		else if (c == ",") k = TK_COMMA;
		else k = TK_UNDEF;
		return k;
	endfunction

	scan_mode_t           mode_q, mode_n, eff_mode;
	logic [7:0]           held_q [4];
	logic [7:0]           held_n [4];
	logic [2:0]           hcnt_q, hcnt_n;
	logic [31:0]          acc_q, acc_n;
	logic                 neg_q, neg_n;
	logic [CNT_W-1:0]     line_q, line_n;
	logic [CNT_W-1:0]     col_q, col_n;
	logic                 seen_q;
	logic [SYM_W-1:0]     q_q [4];
	logic [2:0]           q_cnt_q;
	logic [2:0]           pn;
	tok_t                 tok, pend_q, out_q;
	logic                 pend_valid_q, out_valid_q, out_last_q;
	logic [SYM_W-1:0]     head;
	logic                 is_end, digit, emit, rescan, run_idle;
	logic [7:0]           b;
	logic [3:0]           dval;
	logic                 kw_hit, kw_ok;
	logic [1:0]           kw_idx;
	logic [35:0]          acc_x10;
	logic [31:0]          acc_dig;
	logic                 out_free, shift_out;

	always_comb begin
		head     = cmd.sel_input ? (end_of_input ? {1'b1, 8'h00} : {1'b0, char_byte})
			: q_q[0];
		is_end   = head[SYM_W-1];
		b        = head[7:0];
		digit    = !is_end && b >= "0" && b <= "9";
		dval     = b[3:0];
		acc_x10  = (36'(acc_q) << 3) + (36'(acc_q) << 1) + 36'(dval);
		acc_dig  = (acc_x10 > 36'h080000000) ? 32'h80000000 : acc_x10[31:0];
		eff_mode = (cmd.sel_input && !seen_q) ? M_LINE_END : mode_q;

		mode_n   = eff_mode;
		held_n   = held_q;
		hcnt_n   = hcnt_q;
		acc_n    = acc_q;
		neg_n    = neg_q;
		line_n   = line_q;
		col_n    = col_q;
		emit     = 1'b0;
		rescan   = 1'b0;
		run_idle = 1'b0;
		pn       = 3'd1;
		tok      = '{kind: TK_UNDEF, value: '0, line: '0, col: '0};

		kw_hit = 1'b0;
		kw_idx = 2'd0;
		for (int k = 0; k < 3; k++) begin
			kw_ok = !is_end && (kw_char(2'(k), hcnt_q) == b);
			for (int i = 0; i < 4; i++) begin
				if (3'(i) < hcnt_q && kw_char(2'(k), 3'(i)) != held_q[i]) kw_ok = 1'b0;
			end
			if (kw_ok && !kw_hit) begin
				kw_hit = 1'b1;
				kw_idx = 2'(k);
			end
		end

		unique case (eff_mode)
			M_HOLD: begin
				if (kw_hit) begin
					if (hcnt_q == 3'd4) begin
						col_n     = sat_add(col_q, 3'd5);
						emit      = 1'b1;
						tok.kind  = tok_kind_t'({2'b00, kw_idx});
						tok.col   = rep16(sat_add(col_n, 3'd1));
						hcnt_n    = 3'd0;
						mode_n    = M_IDLE;
					end else begin
						held_n[hcnt_q[1:0]] = b;
						hcnt_n              = hcnt_q + 3'd1;
					end
				end else begin
					col_n     = sat_add(col_q, 3'd1);
					emit      = 1'b1;
					tok.kind  = single_kind(held_q[0]);
					tok.value = (tok.kind == TK_CHAR) ? 32'(held_q[0]) : 32'd0;
					tok.col   = rep16(sat_add(col_n, 3'd1));
					rescan    = 1'b1;
					pn        = hcnt_q;
					hcnt_n    = 3'd0;
					mode_n    = M_IDLE;
				end
			end
			M_SIGN: begin
				if (digit) begin
					acc_n  = 32'(dval);
					mode_n = M_SNUM;
					col_n  = sat_add(col_q, 3'd1);
				end else begin
					emit     = 1'b1;
					tok.kind = TK_UNDEF;
					tok.col  = rep16(sat_add(col_q, 3'd1));
					mode_n   = M_IDLE;
					rescan   = 1'b1;
				end
			end
			M_UNUM, M_SNUM: begin
				if (digit) begin
					acc_n = acc_dig;
					col_n = sat_add(col_q, 3'd1);
				end else begin
					emit    = 1'b1;
					tok.col = rep16(sat_add(col_q, 3'd1));
					if (eff_mode == M_SNUM && acc_q == 32'd0) begin
						tok.kind = TK_UNDEF;
					end else begin
						tok.kind  = TK_NUMBER;
						tok.value = neg_q ? (32'd0 - acc_q)
							: ((acc_q > 32'h7FFFFFFF) ? 32'h7FFFFFFF : acc_q);
					end
					mode_n = M_IDLE;
					rescan = 1'b1;
				end
			end
			M_DISCARD: begin
				if (is_end) begin
					emit     = 1'b1;
					tok.kind = TK_EOF;
					tok.col  = rep16(sat_add(col_q, 3'd1));
				end else if (b == 8'h0A) begin
					mode_n = M_LINE_END;
				end
			end
			M_LINE_END: begin
				if (is_end) begin
					emit     = 1'b1;
					tok.kind = TK_EOF;
					tok.col  = rep16(sat_add(col_q, 3'd1));
				end else begin
					line_n   = sat_add(line_q, 3'd1);
					col_n    = '0;
					mode_n   = M_IDLE;
					run_idle = 1'b1;
				end
			end
			default: begin
				mode_n   = M_IDLE;
				run_idle = 1'b1;
			end
		endcase

		if (run_idle) begin
			priority if (is_end) begin
				emit     = 1'b1;
				tok.kind = TK_EOF;
				tok.col  = rep16(sat_add(col_n, 3'd1));
			end else if (b == 8'h00) begin
				mode_n = M_DISCARD;
			end else if (b == 8'hFF) begin
				emit     = 1'b1;
				tok.kind = TK_EOF;
				tok.col  = 16'd0;
				mode_n   = M_DISCARD;
			end else if (b == 8'h0A) begin
				mode_n = M_LINE_END;
			end else if ((b >= 8'h09 && b <= 8'h0D) || b == 8'h20) begin
				col_n = sat_add(col_n, 3'd1);
			end else if (b == "s" || b == "f") begin
				held_n[0] = b;
				hcnt_n    = 3'd1;
				mode_n    = M_HOLD;
			end else if (digit) begin
				acc_n  = 32'(dval);
				neg_n  = 1'b0;
				mode_n = M_UNUM;
				col_n  = sat_add(col_n, 3'd1);
			end else if (b == "+" || b == "-") begin
				acc_n  = 32'd0;
				neg_n  = (b == "-");
				mode_n = M_SIGN;
				col_n  = sat_add(col_n, 3'd1);
			end else begin
				col_n     = sat_add(col_n, 3'd1);
				emit      = 1'b1;
				tok.kind  = single_kind(b);
				tok.value = (tok.kind == TK_CHAR) ? 32'(b) : 32'd0;
				tok.col   = rep16(sat_add(col_n, 3'd1));
			end
		end

		tok.line = rep16(line_n);
	end

	assign out_free  = !out_valid_q || !token_stall;
	assign shift_out = cmd.step && emit && pend_valid_q;

	always_comb begin
		sts            = '0;
		sts.emit       = emit;
		sts.rescan     = rescan;
		sts.q_last     = (q_cnt_q == 3'd1);
		sts.skip       = end_of_input && !seen_q;
		sts.in_end     = end_of_input;
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			hcnt_q       <= 3'd0;
			acc_q        <= 32'd0;
			neg_q        <= 1'b0;
			line_q       <= '0;
			col_q        <= '0;
			seen_q       <= 1'b0;
			q_cnt_q      <= 3'd0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.clear) begin
				mode_q  <= M_IDLE;
				hcnt_q  <= 3'd0;
				acc_q   <= 32'd0;
				neg_q   <= 1'b0;
				line_q  <= '0;
				col_q   <= '0;
				seen_q  <= 1'b0;
				q_cnt_q <= 3'd0;
			end else if (cmd.step) begin
				mode_q <= mode_n;
				hcnt_q <= hcnt_n;
				acc_q  <= acc_n;
				neg_q  <= neg_n;
				line_q <= line_n;
				col_q  <= col_n;
				seen_q <= seen_q | cmd.sel_input;
				if (rescan) q_cnt_q <= pn;
				else if (cmd.sel_input) q_cnt_q <= 3'd0;
				else q_cnt_q <= q_cnt_q - 3'd1;
			end
			if (cmd.step && emit) pend_valid_q <= 1'b1;
			else if (cmd.flush) pend_valid_q <= 1'b0;
			if (shift_out || cmd.flush) out_valid_q <= 1'b1;
			else if (!token_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			held_q <= held_n;
			if (rescan) begin
				for (int i = 0; i < 3; i++) begin
					q_q[i] <= (3'(i + 1) < pn) ? {1'b0, held_q[i+1]} : head;
				end
				q_q[3] <= head;
			end else if (!cmd.sel_input) begin
				for (int i = 0; i < 3; i++) q_q[i] <= q_q[i+1];
			end
		end
		if (cmd.step && emit) pend_q <= tok;
		if (shift_out) begin
			out_q      <= pend_q;
			out_last_q <= 1'b0;
		end else if (cmd.flush) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign token_kind  = out_q.kind;
	assign token_value = $signed(out_q.value);
	assign line_number = out_q.line;
	assign end_column  = out_q.col;
	assign last_of_run = out_last_q;
	assign token_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== src/dfa_spec_lexer.sv =====
// Top level of the DFA spec lexer: byte beats in, token beats out.
//
// Input channel: one text byte (or an end-of-input mark) per beat on
// char_byte/end_of_input, qualified by byte_valid, back-pressured by byte_stall.
// Output channel: one token per beat on token_kind/token_value/line_number/
// end_column/last_of_run, qualified by token_valid, held while token_stall.
// last_of_run flags the final token caused by one input beat.
// A byte that yields a token has that token moved from the holding register
// to the output register before the next byte is taken. Bytes rescanned after
// a keyword prefix fails or a sign or number ends (up to 4 per beat) are
// scanned again before the next byte is taken. The scan unit handles one
// symbol per cycle while it is not paused for a token hand-off. The last
// token of a beat reaches the output register after its rescanned bytes.
// A token waits in a one-deep holding register until the next token or the
// end of the beat marks whether it is the last; a stalled output register
// holds its token and the scan pauses when a second token needs to leave.
// Reset clears scan state, line and column counters and both valid flags;
// the first byte after reset, or after an end-of-input beat, starts line 1.
`default_nettype none

module dfa_spec_lexer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [7:0]  char_byte,
	input  wire logic        end_of_input,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	output logic [3:0]       token_kind,
	output logic signed [31:0] token_value,
	output logic [15:0]      line_number,
	output logic [15:0]      end_column,
	output logic             last_of_run,
	output logic             token_valid,
	input  wire logic        token_stall
);
	import dsl_pkg::*;

	dsl_cmd_t cmd;
	dsl_sts_t sts;

	dsl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	dsl_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.cmd          (cmd),
		.sts          (sts),
		.token_kind   (token_kind),
		.token_value  (token_value),
		.line_number  (line_number),
		.end_column   (end_column),
		.last_of_run  (last_of_run),
		.token_valid  (token_valid),
		.token_stall  (token_stall)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the DFA spec lexer: byte beats in, token beats checked.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsl_pkg::*;

	localparam int unsigned LIMIT = 2_000_000;
	localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
	localparam int MAX_TOKENS = 6;
	localparam int IDLE_PCT = 29;

	localparam int END_SYM = 256;
	localparam int CH_NUL = 0;
	localparam int CH_EOF_BYTE = 255;
	localparam int CH_TAB = 9;
	localparam int CH_NL = 10;
	localparam int CH_CR = 13;
	localparam int CH_SP = 32;
	localparam int CH_ZERO = "0";
	localparam int CH_NINE = "9";
	localparam int CH_PLUS = "+";
	localparam int CH_MINUS = "-";
	localparam int CH_A = "a";
	localparam int CH_J = "j";
	localparam int CH_N = "n";
	localparam int CH_S = "s";
	localparam int CH_F = "f";
	localparam int CH_LBRACE = "{";
	localparam int CH_RBRACE = "}";
	localparam int CH_EQUALS = "=";
	localparam int CH_COMMA = ",";

	typedef enum logic [2:0] {
		SC_IDLE, SC_HOLD, SC_SIGN, SC_UNUM, SC_SNUM, SC_DISCARD, SC_LINE_END
	} scan_mode_t;

	typedef struct {
		tok_kind_t   kind;
		logic [31:0] value;
		logic [15:0] line;
		logic [15:0] col;
		logic        last;
	} token_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [7:0] char_byte = 8'd0;
	logic end_of_input = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	logic [3:0] token_kind;
	logic signed [31:0] token_value;
	logic [15:0] line_number;
	logic [15:0] end_column;
	logic last_of_run;
	logic token_valid;
	logic token_stall = 1'b0;

	bit calm = 1'b0;
	int errors = 0;
	int beats_sent = 0;
	int tokens_checked = 0;

	string kw_text[3] = '{"sigma", "start", "final"};
	string mark_text = "n{}=,";

	scan_mode_t mode;
	logic [7:0] held [4];
	int unsigned hcnt;
	longint unsigned acc;
	bit neg;
	int unsigned line_cnt;
	int unsigned col_cnt;
	bit seen;
	int sym_q[$];
	token_exp_t beat_tokens[$];
	token_exp_t pending_tokens[$];

	dfa_spec_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_byte(char_byte),
		.end_of_input(end_of_input),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.token_kind(token_kind),
		.token_value(token_value),
		.line_number(line_number),
		.end_column(end_column),
		.last_of_run(last_of_run),
		.token_valid(token_valid),
		.token_stall(token_stall)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int unsigned sat_add(int unsigned v, int unsigned a);
		return (v + a > CNT_MAX) ? CNT_MAX : v + a;
	endfunction

	function automatic void reset_lexer();
		mode = SC_IDLE;
		foreach (held[i]) held[i] = 8'd0;
		hcnt = 0;
		acc = 0;
		neg = 1'b0;
		line_cnt = 0;
		col_cnt = 0;
		seen = 1'b0;
	endfunction

	function automatic void add_token(tok_kind_t k, logic [31:0] v, int unsigned c);
		token_exp_t t;
		if (beat_tokens.size() >= MAX_TOKENS) return;
		t.kind = k;
		t.value = v;
		t.line = (line_cnt > 16'hFFFF) ? 16'hFFFF : 16'(line_cnt);
		t.col = (c > 16'hFFFF) ? 16'hFFFF : 16'(c);
		t.last = 1'b0;
		beat_tokens.push_back(t);
	endfunction

	function automatic tok_kind_t byte_kind(logic [7:0] b);
		if (b >= CH_A && b <= CH_J) return TK_CHAR;
		if (b == CH_N) return TK_N;
		if (b == CH_LBRACE) return TK_LBRACE;
		if (b == CH_RBRACE) return TK_RBRACE;
		if (b == CH_EQUALS) return TK_EQUALS;
		if (b == CH_COMMA) return TK_COMMA;
		return TK_UNDEF;
	endfunction

	function automatic void add_single(logic [7:0] b);
		tok_kind_t k;
		k = byte_kind(b);
		col_cnt = sat_add(col_cnt, 1);
		add_token(k, (k == TK_CHAR) ? {24'd0, b} : 32'd0, sat_add(col_cnt, 1));
	endfunction

	function automatic void add_number();
		logic [31:0] v;
		if (mode == SC_SNUM && acc == 0) begin
			add_token(TK_UNDEF, 32'd0, sat_add(col_cnt, 1));
			return;
		end
		if (neg) v = -acc[31:0];
		else v = (acc > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc[31:0];
		add_token(TK_NUMBER, v, sat_add(col_cnt, 1));
	endfunction

	function automatic void scan_symbol(int x);
		bit digit;
		bit hit;
		int hit_kw;
		int n;
		int k;
		int i;
		digit = (x >= CH_ZERO) && (x <= CH_NINE);
		case (mode)
		SC_HOLD: begin
			n = hcnt;
			hit = 1'b0;
			hit_kw = 0;
			if (x != END_SYM) begin
				for (k = 0; k < 3 && !hit; k++) begin
					hit = kw_text[k][n] == x;
					for (i = 0; i < n && hit; i++)
						hit = kw_text[k][i] == held[i];
					if (hit) hit_kw = k;
				end
			end
			if (hit) begin
				if (n == 4) begin
					col_cnt = sat_add(col_cnt, 5);
					add_token(tok_kind_t'(hit_kw), 32'd0, sat_add(col_cnt, 1));
					hcnt = 0;
					mode = SC_IDLE;
				end else begin
					held[n] = x[7:0];
					hcnt = n + 1;
				end
				return;
			end
			add_single(held[0]);
			sym_q.push_front(x);
			for (i = n - 1; i >= 1; i--) sym_q.push_front(int'(held[i]));
			hcnt = 0;
			mode = SC_IDLE;
			return;
		end
		SC_SIGN: begin
			if (digit) begin
				acc = x - CH_ZERO;
				mode = SC_SNUM;
				col_cnt = sat_add(col_cnt, 1);
			end else begin
				add_token(TK_UNDEF, 32'd0, sat_add(col_cnt, 1));
				mode = SC_IDLE;
				sym_q.push_front(x);
			end
			return;
		end
		SC_UNUM, SC_SNUM: begin
			if (digit) begin
				acc = acc * 10 + (x - CH_ZERO);
				if (acc > 64'h8000_0000) acc = 64'h8000_0000;
				col_cnt = sat_add(col_cnt, 1);
			end else begin
				add_number();
				mode = SC_IDLE;
				sym_q.push_front(x);
			end
			return;
		end
		SC_DISCARD: begin
			if (x == CH_NL) mode = SC_LINE_END;
			else if (x == END_SYM) add_token(TK_EOF, 32'd0, sat_add(col_cnt, 1));
			return;
		end
		SC_LINE_END: begin
			if (x == END_SYM) begin
				add_token(TK_EOF, 32'd0, sat_add(col_cnt, 1));
				return;
			end
			line_cnt = sat_add(line_cnt, 1);
			col_cnt = 0;
			mode = SC_IDLE;
		end
		default: mode = SC_IDLE;
		endcase

		if (x == END_SYM) begin
			add_token(TK_EOF, 32'd0, sat_add(col_cnt, 1));
		end else if (x == CH_NUL) begin
			mode = SC_DISCARD;
		end else if (x == CH_EOF_BYTE) begin
			add_token(TK_EOF, 32'd0, 0);
			mode = SC_DISCARD;
		end else if (x == CH_NL) begin
			mode = SC_LINE_END;
		end else if ((x >= CH_TAB && x <= CH_CR) || x == CH_SP) begin
			col_cnt = sat_add(col_cnt, 1);
		end else if (x == CH_S || x == CH_F) begin
			held[0] = x[7:0];
			hcnt = 1;
			mode = SC_HOLD;
		end else if (digit) begin
			acc = x - CH_ZERO;
			neg = 1'b0;
			mode = SC_UNUM;
			col_cnt = sat_add(col_cnt, 1);
		end else if (x == CH_PLUS || x == CH_MINUS) begin
			acc = 0;
			neg = x == CH_MINUS;
			mode = SC_SIGN;
			col_cnt = sat_add(col_cnt, 1);
		end else begin
			add_single(x[7:0]);
		end
	endfunction

	function automatic void lex_beat(logic [7:0] b, logic e);
		beat_tokens = {};
		if (e) begin
			if (!seen) return;
			sym_q.push_back(END_SYM);
		end else begin
			if (!seen) begin
				seen = 1'b1;
				mode = SC_LINE_END;
			end
			sym_q.push_back(int'(b));
		end
		while (sym_q.size() > 0) scan_symbol(sym_q.pop_front());
		if (e) reset_lexer();
		if (beat_tokens.size() > 0) beat_tokens[$].last = 1'b1;
		foreach (beat_tokens[i]) pending_tokens.push_back(beat_tokens[i]);
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic e);
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				byte_valid <= 1'b0;
				@(posedge clk);
			end
		end
		char_byte <= b;
		end_of_input <= e;
		byte_valid <= 1'b1;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		lex_beat(b, e);
		beats_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void compare_field(string nm, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, nm, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		token_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin : token_check
		token_exp_t want;
		if (arst_n && token_valid && !token_stall) begin
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected token, expected none, actual kind %0d value %0h",
					$time, token_kind, token_value);
				errors++;
			end else begin
				want = pending_tokens.pop_front();
				compare_field("token_kind", 32'(want.kind), 32'(token_kind));
				compare_field("token_value", want.value, token_value);
				compare_field("line_number", 32'(want.line), 32'(line_number));
				compare_field("end_column", 32'(want.col), 32'(end_column));
				compare_field("last_of_run", 32'(want.last), 32'(last_of_run));
				tokens_checked++;
			end
		end
	end

	function automatic string random_number();
		string sign;
		case ($urandom_range(2))
		0: sign = "";
		1: sign = "+";
		default: sign = "-";
		endcase
		case ($urandom_range(3))
		0: return $sformatf("%s%0d", sign, $urandom_range(9));
		1: return $sformatf("%s%0d", sign, $urandom_range(99999));
		2: return $sformatf("%s%0d", sign, $urandom);
		default: return $sformatf("%s%0d%0d", sign, $urandom, $urandom);
		endcase
	endfunction

	function automatic string random_token();
		case ($urandom_range(5))
		0: return kw_text[$urandom_range(2)];
		1: return $sformatf("%c", 8'($urandom_range(CH_A, CH_J)));
		2: return $sformatf("%c", mark_text[$urandom_range(4)]);
		default: return random_number();
		endcase
	endfunction

	task automatic test_keywords_and_marks();
		send_text("sigma start final\n{a,j}=n,");
		send_beat(8'($urandom), 1'b1);
	endtask

	task automatic test_numbers();
		send_text("7 +42 -99999999999 9999999999,-0 +00 -x+");
		send_beat(8'($urandom), 1'b1);
	endtask

	task automatic test_keyword_rescans();
		send_text("stax sigx fina");
		send_beat(8'($urandom), 1'b1);
		send_beat(8'($urandom), 1'b1);
		send_text("s");
		send_beat(8'($urandom), 1'b1);
	endtask

	task automatic test_line_marks();
		send_text("#a");
		send_beat(8'(CH_NUL), 1'b0);
		send_text("zz{\nb");
		send_beat(8'd128, 1'b0);
		send_beat(8'(CH_EOF_BYTE), 1'b0);
		send_text("c\nd\n");
		send_beat(8'($urandom), 1'b1);
	endtask

	task automatic test_random_text(input int beats);
		int first;
		int pick;
		string piece;
		first = beats_sent;
		while (beats_sent - first < beats) begin
			pick = $urandom_range(99);
			if (pick < 60) begin
				piece = random_token();
				case ($urandom_range(4))
				0: piece = {piece, " "};
				1: piece = {piece, "\n"};
				2: piece = {piece, "\t"};
				3: piece = {piece, " = "};
				default: ;
				endcase
				send_text(piece);
			end else if (pick < 70) begin
				send_beat(($urandom_range(3) == 0) ? 8'(CH_NL) : 8'($urandom_range(9, 13)), 1'b0);
			end else if (pick < 80) begin
				send_text(kw_text[$urandom_range(2)].substr(0, $urandom_range(3)));
				send_beat(8'($urandom), 1'b0);
			end else if (pick < 92) begin
				send_beat(8'($urandom), 1'b0);
			end else if (pick < 97) begin
				case ($urandom_range(3))
				0: send_text("-");
				1: send_text("+");
				2: send_text("-0");
				default: send_text("+00");
				endcase
				send_beat(8'($urandom), 1'b0);
			end else begin
				send_beat(8'($urandom), 1'b1);
				if ($urandom_range(2) == 0) send_beat(8'($urandom), 1'b1);
			end
		end
	endtask

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		reset_lexer();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_keywords_and_marks();
		test_numbers();
		test_keyword_rescans();
		test_line_marks();
		wait_drained();
		test_random_text(90);
		calm = 1'b1;
		test_random_text(60);
		calm = 1'b0;
		wait_drained();
		test_random_text(100);
		send_beat(8'($urandom), 1'b1);
		wait_drained();

		$display("run covered %0d input beats: keywords, marks, numbers, rescans, line marks,",
			beats_sent);
		$display("random text with and without idling; %0d tokens checked", tokens_checked);
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
